// ----- rtl/core/rau_pkg.sv -----
package rau_pkg;

  // operation codes
  localparam logic [2:0] FUNC_ADD = 3'd0;
  localparam logic [2:0] FUNC_SUB = 3'd1;
  localparam logic [2:0] FUNC_MUL = 3'd2;
  localparam logic [2:0] FUNC_DIV = 3'd3;
  localparam logic [2:0] FUNC_CMP = 3'd4;

  // compare result codes
  localparam logic [1:0] CMP_EQ   = 2'd0;
  localparam logic [1:0] CMP_A_GT = 2'd1;
  localparam logic [1:0] CMP_B_GT = 2'd2;

  // input item
  typedef struct packed {
    logic        [2:0]  func;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } rau_in_t;

  // result item
  typedef struct packed {
    logic signed [31:0] res_num;
    logic        [30:0] res_den;
    logic        [1:0]  cmp_code;
    logic               overflow;
    logic               zero_den;
  } rau_out_t;

  // datapath commands
  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_MUL_P1,
    DP_MUL_P2,
    DP_MUL_DEN,
    DP_SUM,
    DP_GCD_INIT,
    DP_GCD_STEP,
    DP_DIV_INIT,
    DP_DIV_STEP,
    DP_FIN
  } dp_op_e;

  // datapath status
  typedef struct packed {
    logic bad;
    logic den_zero;
    logic num_zero;
    logic gcd_done;
  } rau_stat_t;

endpackage

// ----- rtl/core/rau_ctrl.sv -----
module rau_ctrl #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  rau_pkg::rau_stat_t stat_i,
  output rau_pkg::dp_op_e    op_o,
  output logic               busy_o,
  output logic               res_valid_o
);
  import rau_pkg::*;

  localparam int unsigned PW = 2 * WORD_BITS;
  localparam int unsigned CW = $clog2(PW);
  localparam logic [CW-1:0] LAST = CW'(PW - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_P1,
    S_MUL_P2,
    S_MUL_DEN,
    S_SUM,
    S_CHECK,
    S_GCD,
    S_DIV,
    S_FIN
  } state_e;

  state_e          state_q, state_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            valid_q, valid_d;

  // sequencing and command decode
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    valid_d = 1'b0;
    op_o    = DP_NOP;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_o    = DP_LOAD;
          state_d = S_MUL_P1;
        end
      end
      S_MUL_P1: begin
        if (stat_i.bad) begin
          state_d = S_FIN;
        end else begin
          op_o    = DP_MUL_P1;
          state_d = S_MUL_P2;
        end
      end
      S_MUL_P2: begin
        op_o    = DP_MUL_P2;
        state_d = S_MUL_DEN;
      end
      S_MUL_DEN: begin
        op_o    = DP_MUL_DEN;
        state_d = S_SUM;
      end
      S_SUM: begin
        op_o    = DP_SUM;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (stat_i.den_zero || stat_i.num_zero) begin
          state_d = S_FIN;
        end else begin
          op_o    = DP_GCD_INIT;
          state_d = S_GCD;
        end
      end
      S_GCD: begin
        if (stat_i.gcd_done) begin
          op_o    = DP_DIV_INIT;
          cnt_d   = LAST;
          state_d = S_DIV;
        end else begin
          op_o = DP_GCD_STEP;
        end
      end
      S_DIV: begin
        op_o = DP_DIV_STEP;
        if (cnt_q == '0) begin
          state_d = S_FIN;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_FIN: begin
        op_o    = DP_FIN;
        valid_d = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state and strobe registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
    end
  end

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = valid_q;

endmodule

// ----- rtl/core/rau_datapath.sv -----
module rau_datapath #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rau_pkg::dp_op_e    op_i,
  input  rau_pkg::rau_in_t   in_i,
  output rau_pkg::rau_stat_t stat_o,
  output rau_pkg::rau_out_t  res_o
);
  import rau_pkg::*;

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned PW = 2 * W;
  localparam int unsigned KW = $clog2(PW);
  localparam logic [PW-1:0] HALF = PW'(1) << (W - 1);
  localparam logic [PW-1:0] LIM  = HALF - PW'(1);

  function automatic logic [W-1:0] mag_f(input logic [W-1:0] v);
    mag_f = v[W-1] ? (~v + 1'b1) : v;
  endfunction

  logic [2:0]    func_q;
  logic [W-1:0]  an_m_q, ad_m_q, bn_m_q, bd_m_q;
  logic          an_s_q, ad_s_q, bn_s_q, bd_s_q;
  logic [PW-1:0] p1_q, p2_q, nm_q, dm_q;
  logic          s1_q, s2_q, ns_q, ds_q;
  logic [PW-1:0] gx_q, gy_q, g_q, rn_q, rd_q;
  logic [KW-1:0] k_q;
  rau_out_t      res_q;

  logic [W-1:0]  ma, mb;
  logic          sa, sb;
  logic [PW-1:0] prod;
  logic          psign;
  logic          s2e, ss;
  logic [PW-1:0] sum;
  logic          x_gt;
  logic [PW-1:0] diff;
  logic [PW:0]   tn, td, gw;
  logic          qn, qd;
  logic          neg, ovf;
  logic [PW-1:0] den_v;
  logic [31:0]   num32;
  rau_out_t      fin;

  // multiplier operand select
  always_comb begin
    unique case (op_i)
      DP_MUL_P2: begin
        ma = ad_m_q; sa = ad_s_q;
        mb = bn_m_q; sb = bn_s_q;
      end
      DP_MUL_DEN: begin
        ma = ad_m_q; sa = ad_s_q;
        mb = (func_q == FUNC_DIV) ? bn_m_q : bd_m_q;
        sb = (func_q == FUNC_DIV) ? bn_s_q : bd_s_q;
      end
      default: begin
        ma = an_m_q; sa = an_s_q;
        mb = (func_q == FUNC_MUL) ? bn_m_q : bd_m_q;
        sb = (func_q == FUNC_MUL) ? bn_s_q : bd_s_q;
      end
    endcase
  end

  // shared magnitude multiplier
  assign prod  = PW'(ma) * PW'(mb);
  assign psign = (prod != '0) && (sa != sb);

  // sign-magnitude sum of the cross products
  always_comb begin
    s2e = ((func_q != FUNC_ADD) && (p2_q != '0)) ? !s2_q : s2_q;
    if (s1_q == s2e) begin
      sum = p1_q + p2_q;
      ss  = s1_q;
    end else if (p1_q >= p2_q) begin
      sum = p1_q - p2_q;
      ss  = s1_q;
    end else begin
      sum = p2_q - p1_q;
      ss  = s2e;
    end
    if (sum == '0) begin
      ss = 1'b0;
    end
  end

  // binary gcd compare and subtract
  assign x_gt = gx_q > gy_q;
  assign diff = x_gt ? (gx_q - gy_q) : (gy_q - gx_q);

  // restoring division lanes, numerator and denominator by the gcd
  assign gw = {1'b0, g_q};
  assign tn = {rn_q, nm_q[PW-1]};
  assign td = {rd_q, dm_q[PW-1]};
  assign qn = tn >= gw;
  assign qd = td >= gw;

  // result assembly
  always_comb begin
    fin   = '0;
    neg   = (nm_q != '0) && (ns_q != ds_q);
    den_v = (nm_q == '0) ? PW'(1) : dm_q;
    ovf   = (neg ? (nm_q > HALF) : (nm_q > LIM)) || (den_v > LIM);
    num32 = 32'(nm_q[W-1:0]);
    if (!stat_o.bad) begin
      if (dm_q == '0) begin
        fin.zero_den = 1'b1;
      end else begin
        if (func_q == FUNC_CMP) begin
          fin.cmp_code = (nm_q == '0) ? CMP_EQ : (neg ? CMP_B_GT : CMP_A_GT);
        end
        if (ovf) begin
          fin.overflow = 1'b1;
        end else begin
          fin.res_num = neg ? (32'd0 - num32) : num32;
          fin.res_den = 31'(den_v[W-2:0]);
        end
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    unique case (op_i)
      DP_LOAD: begin
        func_q <= in_i.func;
        an_s_q <= in_i.a_num[W-1];
        ad_s_q <= in_i.a_den[W-1];
        bn_s_q <= in_i.b_num[W-1];
        bd_s_q <= in_i.b_den[W-1];
        an_m_q <= mag_f(in_i.a_num[W-1:0]);
        ad_m_q <= mag_f(in_i.a_den[W-1:0]);
        bn_m_q <= mag_f(in_i.b_num[W-1:0]);
        bd_m_q <= mag_f(in_i.b_den[W-1:0]);
      end
      DP_MUL_P1: begin
        p1_q <= prod;
        s1_q <= psign;
      end
      DP_MUL_P2: begin
        p2_q <= prod;
        s2_q <= psign;
      end
      DP_MUL_DEN: begin
        dm_q <= prod;
        ds_q <= psign;
      end
      DP_SUM: begin
        if ((func_q == FUNC_MUL) || (func_q == FUNC_DIV)) begin
          nm_q <= p1_q;
          ns_q <= s1_q;
        end else begin
          nm_q <= sum;
          ns_q <= ss;
        end
      end
      DP_GCD_INIT: begin
        gx_q <= nm_q;
        gy_q <= dm_q;
        k_q  <= '0;
      end
      DP_GCD_STEP: begin
        priority if (!gx_q[0] && !gy_q[0]) begin
          gx_q <= gx_q >> 1;
          gy_q <= gy_q >> 1;
          k_q  <= k_q + 1'b1;
        end else if (!gx_q[0]) begin
          gx_q <= gx_q >> 1;
        end else if (!gy_q[0]) begin
          gy_q <= gy_q >> 1;
        end else if (x_gt) begin
          gx_q <= gy_q;
          gy_q <= diff;
        end else begin
          gy_q <= diff;
        end
      end
      DP_DIV_INIT: begin
        g_q  <= gx_q << k_q;
        rn_q <= '0;
        rd_q <= '0;
      end
      DP_DIV_STEP: begin
        rn_q <= qn ? PW'(tn - gw) : tn[PW-1:0];
        rd_q <= qd ? PW'(td - gw) : td[PW-1:0];
        nm_q <= {nm_q[PW-2:0], qn};
        dm_q <= {dm_q[PW-2:0], qd};
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else if (op_i == DP_FIN) begin
      res_q <= fin;
    end
  end

  assign stat_o.bad      = func_q > FUNC_CMP;
  assign stat_o.den_zero = dm_q == '0;
  assign stat_o.num_zero = nm_q == '0;
  assign stat_o.gcd_done = gy_q == '0;
  assign res_o           = res_q;

endmodule

// ----- rtl/core/rational_arith_unit_top.sv -----
// Exact arithmetic on two signed fractions (add, subtract, multiply, divide, compare) with
// the result reduced by its gcd and the sign on the numerator. An item is taken when start
// is high while busy is low. The time a normal item takes from the accepting edge to the
// result strobe is data dependent: it is set by the binary gcd loop on the 2*WORD_BITS-bit
// intermediates and by the bit-serial division of numerator and denominator by the gcd.
// A zero numerator or zero denominator skips the gcd and the division, an unused operation
// code also skips the multiplies and the sum. The result is marked on res_o by res_valid_o
// for one cycle and cannot be held off by the receiver; busy is already low in that cycle,
// so the next item may start then.
module rational_arith_unit_top #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  rau_pkg::rau_in_t  in_i,
  output logic              res_valid_o,
  output rau_pkg::rau_out_t res_o
);
  import rau_pkg::*;

  dp_op_e    op;
  rau_stat_t stat;

  // sequencer
  rau_ctrl #(
    .WORD_BITS(WORD_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .stat_i      (stat),
    .op_o        (op),
    .busy_o      (busy),
    .res_valid_o (res_valid_o)
  );

  // arithmetic, gcd and division
  rau_datapath #(
    .WORD_BITS(WORD_BITS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (op),
    .in_i   (in_i),
    .stat_o (stat),
    .res_o  (res_o)
  );

endmodule

// ----- rtl/core/rau_checker.sv -----
module rau_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              res_valid_o,
  input rau_pkg::rau_out_t res_o
);
  import rau_pkg::*;

  // accepted item makes the unit busy
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("item accepted but unit not busy");

  // busy ends exactly when the result strobe shows
  a_fell_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> res_valid_o)
    else $error("busy dropped without a result");

  // strobe lasts one cycle
  a_strobe_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("result strobe longer than one cycle");

  // zero denominator clears the value fields
  a_zero_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.zero_den |->
      (res_o.res_num == '0) && (res_o.res_den == '0) && !res_o.overflow)
    else $error("zero denominator result carries a value");

  // overflow clears the value fields
  a_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.overflow |-> (res_o.res_num == '0) && (res_o.res_den == '0))
    else $error("overflow result carries a value");

endmodule

bind rational_arith_unit_top rau_checker u_rau_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import rau_pkg::*;

  localparam int WORD_MIN = 32'sh8000_0000;
  localparam int WORD_MAX = 32'sh7fff_ffff;
  localparam int RANDOM_ITEMS = 1250;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 250;
  localparam bit [63:0] HALF_RANGE = 64'h0000_0000_8000_0000;

  // expected fractions for accepted items, checked in order
  class rational_result_board;
    rau_out_t expected_fractions[$];
    int errors;
    int mismatches;

    // sign and magnitude of a signed product
    function automatic bit [63:0] product_mag(longint x, longint y, output bit neg);
      bit [63:0] mx, my, m;
      mx = (x < 0) ? 64'(-x) : 64'(x);
      my = (y < 0) ? 64'(-y) : 64'(y);
      m = mx * my;
      neg = (m != 0) && ((x < 0) != (y < 0));
      return m;
    endfunction

    // exact result reduced by the gcd, sign on the numerator
    function automatic rau_out_t reduced_fraction(rau_in_t it);
      longint an, ad, bn, bd;
      bit [63:0] p1, p2, nm, dm, x, y, t;
      bit s1, s2, ns, ds, neg;
      rau_out_t r;
      r = '0;
      if (it.func > FUNC_CMP) return r;
      an = $signed(it.a_num);
      ad = $signed(it.a_den);
      bn = $signed(it.b_num);
      bd = $signed(it.b_den);
      case (it.func)
        FUNC_MUL: begin
          nm = product_mag(an, bn, ns);
          dm = product_mag(ad, bd, ds);
        end
        FUNC_DIV: begin
          nm = product_mag(an, bd, ns);
          dm = product_mag(ad, bn, ds);
        end
        default: begin
          // add, subtract and compare share the cross-product sum
          p1 = product_mag(an, bd, s1);
          p2 = product_mag(ad, bn, s2);
          if (it.func != FUNC_ADD && p2 != 0) s2 = !s2;
          if (s1 == s2) begin
            nm = p1 + p2;
            ns = s1;
          end else if (p1 >= p2) begin
            nm = p1 - p2;
            ns = s1;
          end else begin
            nm = p2 - p1;
            ns = s2;
          end
          if (nm == 0) ns = 1'b0;
          dm = product_mag(ad, bd, ds);
        end
      endcase
      if (dm == 0) begin
        r.zero_den = 1'b1;
        return r;
      end
      neg = (nm != 0) && (ns != ds);
      if (it.func == FUNC_CMP) r.cmp_code = (nm == 0) ? CMP_EQ : (neg ? CMP_B_GT : CMP_A_GT);
      // euclid on magnitudes
      if (nm == 0) begin
        dm = 1;
      end else begin
        x = nm;
        y = dm;
        while (y != 0) begin
          t = x % y;
          x = y;
          y = t;
        end
        nm = nm / x;
        dm = dm / x;
      end
      if ((neg ? nm > HALF_RANGE : nm > HALF_RANGE - 1) || dm > HALF_RANGE - 1) begin
        r.overflow = 1'b1;
      end else begin
        r.res_num = neg ? 32'(-nm) : 32'(nm);
        r.res_den = 31'(dm);
      end
      return r;
    endfunction

    function void note_operands(rau_in_t it);
      expected_fractions.push_back(reduced_fraction(it));
    endfunction

    function void check_result(rau_out_t got);
      rau_out_t want;
      if (expected_fractions.size() == 0) begin
        errors++;
        if (mismatches < 10)
          $display("unexpected result: num=%0d den=%0d cmp=%0d ovf=%0b zd=%0b",
                   got.res_num, got.res_den, got.cmp_code, got.overflow, got.zero_den);
        mismatches++;
        return;
      end
      want = expected_fractions.pop_front();
      if (got.res_num !== want.res_num || got.res_den !== want.res_den ||
          got.cmp_code !== want.cmp_code || got.overflow !== want.overflow ||
          got.zero_den !== want.zero_den) begin
        errors++;
        if (mismatches < 10)
          $display("mismatch: expected num=%0d den=%0d cmp=%0d ovf=%0b zd=%0b, got num=%0d den=%0d cmp=%0d ovf=%0b zd=%0b",
                   want.res_num, want.res_den, want.cmp_code, want.overflow, want.zero_den,
                   got.res_num, got.res_den, got.cmp_code, got.overflow, got.zero_den);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_fractions.size();
    endfunction
  endclass

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  rau_in_t  in_item;
  logic     res_valid_o;
  rau_out_t res_o;

  rational_result_board board;
  int no_wait_left;

  rational_arith_unit_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .in_i       (in_item),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // known input values from time zero
  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    in_item = '0;
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) board.check_result(res_o);
  end

  // watchdog on cycles with no handshake at all
  initial begin
    int stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((start && !busy) || res_valid_o) stalled = 0;
      else stalled++;
    end
    $display("rational_arith_unit_top test failed");
    $finish;
  end

  function automatic rau_in_t make_item(logic [2:0] f, int an, int ad, int bn, int bd);
    rau_in_t it;
    it.func = f;
    it.a_num = an;
    it.a_den = ad;
    it.b_num = bn;
    it.b_den = bd;
    return it;
  endfunction

  // operand mix: small values, shared factors, extremes, full range
  function automatic int pick_operand();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2: v = int'($urandom_range(0, 40)) - 20;
      3:       v = (int'($urandom_range(0, 24)) - 12) * int'($urandom_range(1, 65536));
      4: begin
        case ($urandom_range(0, 5))
          0: v = WORD_MIN;
          1: v = WORD_MAX;
          2: v = 0;
          3: v = 1;
          4: v = -1;
          default: v = WORD_MIN + 1;
        endcase
      end
      default: v = int'($urandom);
    endcase
    return v;
  endfunction

  function automatic int pick_denominator();
    int v;
    if ($urandom_range(0, 49) == 0) return 0;
    v = pick_operand();
    return (v == 0) ? 1 : v;
  endfunction

  // sender idle before an item, with bursts of back-to-back items
  function automatic int unsigned draw_gap();
    if (no_wait_left > 0) begin
      no_wait_left--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) no_wait_left = $urandom_range(10, 40);
    return $urandom_range(0, 7);
  endfunction

  // present one item and hold it until accepted; called and returns at a falling edge
  task automatic send_item(input rau_in_t it);
    int unsigned gap;
    gap = draw_gap();
    if (gap != 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_item = it;
    start = 1'b1;
    do @(posedge clk_i); while (busy);
    board.note_operands(it);
    @(negedge clk_i);
  endtask

  // stimulus
  initial begin
    rau_in_t it;
    int valid_sent;
    board = new();
    no_wait_left = 0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed items
    send_item(make_item(FUNC_ADD, 1, 2, 1, 3));
    send_item(make_item(FUNC_SUB, 1, 2, 1, 2));
    send_item(make_item(FUNC_MUL, WORD_MIN, 1, -1, 1));
    send_item(make_item(FUNC_DIV, 3, 4, -9, 8));
    send_item(make_item(FUNC_CMP, 1, 2, 2, 4));
    send_item(make_item(FUNC_CMP, -1, 3, 1, 3));
    send_item(make_item(FUNC_CMP, 7, -2, -4, 1));
    send_item(make_item(FUNC_ADD, WORD_MAX, 1, 1, 1));
    send_item(make_item(FUNC_MUL, WORD_MAX, WORD_MIN, WORD_MIN, WORD_MAX));
    send_item(make_item(FUNC_DIV, 1, 1, 0, 5));
    send_item(make_item(FUNC_ADD, 1, 0, 1, 1));
    send_item(make_item(FUNC_MUL, 0, 0, 0, 0));
    send_item(make_item(3'd5, -1, -1, -1, -1));
    send_item(make_item(3'd6, WORD_MAX, WORD_MIN, 7, 0));
    send_item(make_item(3'd7, -1, -1, -1, -1));
    send_item(make_item(FUNC_DIV, 1, 1, 1, WORD_MIN));
    send_item(make_item(FUNC_SUB, 1, WORD_MIN, 0, 1));
    send_item(make_item(FUNC_ADD, -1, -1, -1, -1));
    send_item(make_item(FUNC_MUL, WORD_MIN, WORD_MIN, WORD_MAX, WORD_MAX));
    send_item(make_item(FUNC_SUB, WORD_MIN, 1, WORD_MAX, 1));
    send_item(make_item(FUNC_CMP, WORD_MIN, 1, WORD_MAX, 1));
    send_item(make_item(FUNC_ADD, 1, WORD_MAX, 1, WORD_MAX - 1));
    send_item(make_item(FUNC_MUL, 0, WORD_MIN, 5, 7));
    send_item(make_item(FUNC_CMP, 0, -3, 0, 9));
    send_item(make_item(FUNC_CMP, 5, 0, 1, 1));

    // random items; unused codes do not count
    valid_sent = 0;
    while (valid_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 19) == 0) it.func = 3'($urandom_range(5, 7));
      else it.func = 3'($urandom_range(0, 4));
      it.a_num = pick_operand();
      it.a_den = pick_denominator();
      it.b_num = pick_operand();
      it.b_den = pick_denominator();
      send_item(it);
      if (it.func <= FUNC_CMP) valid_sent++;
    end
    start = 1'b0;

    // drain
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("rational_arith_unit_top test passed");
    end else begin
      $display("rational_arith_unit_top test failed");
    end
    $finish;
  end

endmodule
